### hw/rtl/rbes_pkg.sv
// Shared types, constants and helper functions for the rigid body integrator.
`timescale 1ns / 1ps
`default_nettype none
package rbes_pkg;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_BODY_MASS      = 3'd0;
    localparam logic [2:0] REG_INERTIA_X      = 3'd1;
    localparam logic [2:0] REG_INERTIA_Y      = 3'd2;
    localparam logic [2:0] REG_INERTIA_Z      = 3'd3;
    localparam logic [2:0] REG_FLOOR_ALTITUDE = 3'd4;
    localparam logic [2:0] REG_FRICTION_COEFF = 3'd5;
    localparam logic [2:0] REG_GRAVITY_ACCEL  = 3'd6;

    localparam logic [30:0]        RST_BODY_MASS = 31'd65536000;
    localparam logic [30:0]        RST_INERTIA   = 31'd65536;
    localparam logic [30:0]        RST_GRAVITY   = 31'd642908;
    localparam logic signed [32:0] NEAR_FLOOR    = 33'sd6554;
    localparam logic signed [63:0] MIN_HSPEED    = 64'sd655;
    localparam logic signed [31:0] QUAT_ONE      = 32'sh4000_0000;
    localparam logic signed [49:0] DQ_LIMIT      = 50'sd70368744177663;
    localparam logic signed [63:0] Q_LIMIT       = 64'sd2147483647;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
        logic [16:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        speed;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } t_out_item;

    // request to the shared divide / square-root unit
    typedef struct packed {
        logic               start;
        logic               is_sqrt;
        logic signed [63:0] num;
        logic [31:0]        den;
    } t_ds_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } t_ds_rsp;

    typedef struct packed {
        logic [1:0] c;
        logic [1:0] qi;
        logic [1:0] wi;
        logic       neg;
        logic       first;
        logic       last;
    } t_dq_term;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [30:0] satu31(input logic [63:0] v);
        if (v > 64'd2147483647) begin
            return 31'h7fff_ffff;
        end else begin
            return v[30:0];
        end
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] tdiv_p2(input logic signed [63:0] v,
                                                   input int unsigned k);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (v + bias) >>> k;
    endfunction

    // terms of q * (0, w): component, q index, w index, sign
    function automatic t_dq_term dq_term(input logic [3:0] t);
        t_dq_term d;
        d = '0;
        unique case (t)
            4'd0:  d = '{c: 2'd0, qi: 2'd1, wi: 2'd0, neg: 1'b1, first: 1'b1, last: 1'b0};
            4'd1:  d = '{c: 2'd0, qi: 2'd2, wi: 2'd1, neg: 1'b1, first: 1'b0, last: 1'b0};
            4'd2:  d = '{c: 2'd0, qi: 2'd3, wi: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b1};
            4'd3:  d = '{c: 2'd1, qi: 2'd0, wi: 2'd0, neg: 1'b0, first: 1'b1, last: 1'b0};
            4'd4:  d = '{c: 2'd1, qi: 2'd2, wi: 2'd2, neg: 1'b0, first: 1'b0, last: 1'b0};
            4'd5:  d = '{c: 2'd1, qi: 2'd3, wi: 2'd1, neg: 1'b1, first: 1'b0, last: 1'b1};
            4'd6:  d = '{c: 2'd2, qi: 2'd0, wi: 2'd1, neg: 1'b0, first: 1'b1, last: 1'b0};
            4'd7:  d = '{c: 2'd2, qi: 2'd1, wi: 2'd2, neg: 1'b1, first: 1'b0, last: 1'b0};
            4'd8:  d = '{c: 2'd2, qi: 2'd3, wi: 2'd0, neg: 1'b0, first: 1'b0, last: 1'b1};
            4'd9:  d = '{c: 2'd3, qi: 2'd0, wi: 2'd2, neg: 1'b0, first: 1'b1, last: 1'b0};
            4'd10: d = '{c: 2'd3, qi: 2'd1, wi: 2'd1, neg: 1'b0, first: 1'b0, last: 1'b0};
            4'd11: d = '{c: 2'd3, qi: 2'd2, wi: 2'd0, neg: 1'b1, first: 1'b0, last: 1'b1};
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/rbes_divsqrt.sv
// Shared iterative unit: signed 64/32 divide (64 steps) or 64-bit integer square root (32 steps).
`timescale 1ns / 1ps
`default_nettype none
module rbes_divsqrt import rbes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ds_req i_req,
    output t_ds_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_n;
    logic [63:0] r_q;
    logic [35:0] r_rem;
    logic [31:0] r_den;

    logic [63:0] mag;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [36:0] diff;
    logic        ge;

    always_comb begin
        mag    = i_req.num[63] ? 64'(-i_req.num) : 64'(i_req.num);
        rem_sh = r_sqrt ? {r_rem[33:0], r_n[63:62]} : {r_rem[34:0], r_n[63]};
        trial  = r_sqrt ? {r_q[33:0], 2'b01} : {4'b0, r_den};
        diff   = {1'b0, rem_sh} - {1'b0, trial};
        ge     = ~diff[36];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_neg  <= i_req.num[63] & ~i_req.is_sqrt;
                r_n    <= i_req.is_sqrt ? 64'(i_req.num) : mag;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= i_req.is_sqrt ? 6'd31 : 6'd63;
            end else if (r_busy) begin
                r_rem <= ge ? diff[35:0] : rem_sh;
                r_q   <= {r_q[62:0], ge};
                r_n   <= r_sqrt ? {r_n[61:0], 2'b00} : {r_n[62:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule
`default_nettype wire

### hw/rtl/rigid_body_euler_step.sv
// Top level of the rigid body semi-implicit Euler integrator.
// Run time per item depends on whether the body is near the floor, whether ground friction
// applies, and whether the new quaternion has zero norm, which skips the normalising divides.
// The shared divide / square-root unit performs 6 to 12 divides and 2 or 3 roots per item;
// products use one 33x33 multiplier.
// Items are taken one at a time, only while idle; the result register frees the input side.
// Reset (synchronous, active low): registers to defaults, body at rest at origin.
`timescale 1ns / 1ps
`default_nettype none
module rigid_body_euler_step import rbes_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [5:0] S_IDLE = 6'd0,  S_GND  = 6'd1,  S_HM0  = 6'd2,  S_HM2 = 6'd3;
    localparam logic [5:0] S_HS   = 6'd4,  S_HQ   = 6'd5,  S_HW   = 6'd6,  S_FMA = 6'd7;
    localparam logic [5:0] S_FMB  = 6'd8,  S_FMC  = 6'd9,  S_FMD  = 6'd10, S_FRM = 6'd11;
    localparam logic [5:0] S_FRD  = 6'd12, S_FRW  = 6'd13, S_AD   = 6'd14, S_AW  = 6'd15;
    localparam logic [5:0] S_AM   = 6'd16, S_AU   = 6'd17, S_PM   = 6'd18, S_PU  = 6'd19;
    localparam logic [5:0] S_PS   = 6'd20, S_SQ   = 6'd21, S_SW   = 6'd22, S_DM  = 6'd23;
    localparam logic [5:0] S_DA   = 6'd24, S_QH   = 6'd25, S_QL   = 6'd26, S_QU  = 6'd27;
    localparam logic [5:0] S_QS   = 6'd28, S_QA   = 6'd29, S_NQ   = 6'd30, S_NW  = 6'd31;
    localparam logic [5:0] S_ND   = 6'd32, S_NDW  = 6'd33, S_DONE = 6'd34;

    // configuration
    logic [30:0]        r_mass, r_inx, r_iny, r_inz, r_coeff, r_grav;
    logic signed [31:0] r_floor;

    // body state
    logic signed [31:0] r_pos  [3];
    logic signed [31:0] r_vel  [3];
    logic signed [31:0] r_spin [3];
    logic signed [31:0] r_q    [4];

    // sequencer and working registers
    logic [5:0]         r_st;
    logic [1:0]         r_ax;
    logic               r_rot;
    logic [3:0]         r_t;
    t_in_item           r_in;
    logic signed [33:0] r_f [3];
    logic [31:0]        r_h;
    logic [30:0]        r_fm;
    logic signed [31:0] r_acc;
    logic [63:0]        r_sum;
    logic signed [63:0] r_p;
    logic signed [63:0] r_hp;
    logic signed [49:0] r_dqacc;
    logic signed [46:0] r_dq [4];
    logic [31:0]        r_n;
    logic [30:0]        r_speed;
    t_out_item          r_out;
    logic               r_ovalid;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [32:0]        dt33;
    logic [30:0]        mass_eff, inr_eff;
    logic signed [31:0] tq_sel;
    logic signed [63:0] p16;
    logic signed [31:0] ax_new;
    logic signed [31:0] pos_new;
    logic signed [31:0] pos_fin;
    logic               near;
    t_dq_term           term;
    logic signed [49:0] dq_tv, dq_sum;
    logic signed [46:0] dq_cl;
    logic signed [30:0] dh;
    logic signed [63:0] q_prod, q_wide;
    logic signed [31:0] q_cl;
    t_ds_req            ds_req;
    t_ds_rsp            ds_rsp;
    logic               in_xfer, out_xfer, cfg_wr, out_load;

    assign in_xfer  = i_in_valid & o_in_ready;
    assign out_xfer = r_ovalid & i_out_ready;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign out_load = (r_st == S_DONE) & (~r_ovalid | i_out_ready);

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass  <= RST_BODY_MASS;
            r_inx   <= RST_INERTIA;
            r_iny   <= RST_INERTIA;
            r_inz   <= RST_INERTIA;
            r_floor <= '0;
            r_coeff <= '0;
            r_grav  <= RST_GRAVITY;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_BODY_MASS:      r_mass  <= pwdata[30:0];
                REG_INERTIA_X:      r_inx   <= pwdata[30:0];
                REG_INERTIA_Y:      r_iny   <= pwdata[30:0];
                REG_INERTIA_Z:      r_inz   <= pwdata[30:0];
                REG_FLOOR_ALTITUDE: r_floor <= pwdata;
                REG_FRICTION_COEFF: r_coeff <= pwdata[30:0];
                REG_GRAVITY_ACCEL:  r_grav  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_BODY_MASS:      prdata = {1'b0, r_mass};
            REG_INERTIA_X:      prdata = {1'b0, r_inx};
            REG_INERTIA_Y:      prdata = {1'b0, r_iny};
            REG_INERTIA_Z:      prdata = {1'b0, r_inz};
            REG_FLOOR_ALTITUDE: prdata = r_floor;
            REG_FRICTION_COEFF: prdata = {1'b0, r_coeff};
            REG_GRAVITY_ACCEL:  prdata = {1'b0, r_grav};
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // datapath around the shared multiplier
    always_comb begin
        dt33     = {16'b0, r_in.time_step};
        mass_eff = (r_mass == '0) ? 31'd1 : r_mass;
        unique case (r_ax)
            2'd0:    begin inr_eff = r_inx; tq_sel = r_in.torque_x; end
            2'd1:    begin inr_eff = r_iny; tq_sel = r_in.torque_y; end
            default: begin inr_eff = r_inz; tq_sel = r_in.torque_z; end
        endcase
        if (inr_eff == '0) begin
            inr_eff = 31'd1;
        end
        term = dq_term(r_t);
        dh   = r_dq[r_ax][46:16];

        mul_a = '0;
        mul_b = '0;
        unique case (r_st)
            S_HM0: begin mul_a = r_vel[0]; mul_b = r_vel[0]; end
            S_HM2: begin mul_a = r_vel[2]; mul_b = r_vel[2]; end
            S_FMA: begin mul_a = {2'b0, r_coeff}; mul_b = {2'b0, r_mass}; end
            S_FMC: begin mul_a = {2'b0, r_fm}; mul_b = {2'b0, r_grav}; end
            S_FRM: begin mul_a = r_vel[r_ax]; mul_b = {2'b0, r_fm}; end
            S_AM:  begin mul_a = r_acc; mul_b = dt33; end
            S_PM:  begin mul_a = r_vel[r_ax]; mul_b = dt33; end
            S_PU:  begin mul_a = r_vel[r_ax]; mul_b = r_vel[r_ax]; end
            S_DM:  begin mul_a = r_q[term.qi]; mul_b = r_spin[term.wi]; end
            S_QH:  begin mul_a = dh; mul_b = dt33; end
            S_QL:  begin mul_a = {17'b0, r_dq[r_ax][15:0]}; mul_b = dt33; end
            S_QS:  begin mul_a = r_q[r_ax]; mul_b = r_q[r_ax]; end
            default: ;
        endcase
        mul_p = mul_a * mul_b;

        p16     = tdiv_p2(r_p, 16);
        ax_new  = sat32((r_rot ? 64'(r_spin[r_ax]) : 64'(r_vel[r_ax])) + p16);
        pos_new = sat32(64'(r_pos[r_ax]) + p16);
        pos_fin = (r_ax == 2'd1 && pos_new < r_floor) ? r_floor : pos_new;
        near    = 33'(r_pos[1]) <= 33'(r_floor) + NEAR_FLOOR;

        dq_tv  = p16[49:0];
        dq_sum = (term.first ? 50'sd0 : r_dqacc) + (term.neg ? -dq_tv : dq_tv);
        if (dq_sum > DQ_LIMIT) begin
            dq_cl = DQ_LIMIT[46:0];
        end else if (dq_sum < -DQ_LIMIT) begin
            dq_cl = 47'(-DQ_LIMIT);
        end else begin
            dq_cl = dq_sum[46:0];
        end

        q_prod = r_hp + r_p;
        q_wide = 64'(r_q[r_ax]) + tdiv_p2(q_prod, 17);
        if (q_wide > Q_LIMIT) begin
            q_cl = 32'sh7fff_ffff;
        end else if (q_wide < -Q_LIMIT) begin
            q_cl = -32'sh7fff_ffff;
        end else begin
            q_cl = q_wide[31:0];
        end

        ds_req = '0;
        unique case (r_st)
            S_HQ, S_SQ, S_NQ: begin
                ds_req.start   = 1'b1;
                ds_req.is_sqrt = 1'b1;
                ds_req.num     = $signed(r_sum);
            end
            S_FRD: begin
                ds_req.start = 1'b1;
                ds_req.num   = r_p;
                ds_req.den   = r_h;
            end
            S_AD: begin
                ds_req.start = 1'b1;
                ds_req.num   = (r_rot ? 64'(tq_sel) : 64'(r_f[r_ax])) <<< 16;
                ds_req.den   = {1'b0, r_rot ? inr_eff : mass_eff};
            end
            S_ND: begin
                ds_req.start = 1'b1;
                ds_req.num   = 64'(r_q[r_ax]) <<< 30;
                ds_req.den   = r_n;
            end
            default: ;
        endcase
    end

    rbes_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .o_rsp   (ds_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_p <= mul_p[63:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ax     <= '0;
            r_rot    <= 1'b0;
            r_t      <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i]  <= '0;
                r_vel[i]  <= '0;
                r_spin[i] <= '0;
            end
            r_q[0] <= QUAT_ONE;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
        end else begin
            if (out_xfer && !out_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_in   <= i_in_data;
                        r_f[0] <= 34'(i_in_data.force_x);
                        r_f[1] <= 34'(i_in_data.force_y);
                        r_f[2] <= 34'(i_in_data.force_z);
                        r_ax   <= '0;
                        r_rot  <= 1'b0;
                        r_st   <= S_GND;
                    end
                end
                S_GND: r_st <= near ? S_HM0 : S_AD;
                S_HM0: r_st <= S_HM2;
                S_HM2: begin r_sum <= $unsigned(r_p); r_st <= S_HS; end
                S_HS:  begin r_sum <= r_sum + $unsigned(r_p); r_st <= S_HQ; end
                S_HQ:  r_st <= S_HW;
                S_HW: begin
                    if (ds_rsp.done) begin
                        r_h  <= ds_rsp.res[31:0];
                        r_st <= (ds_rsp.res > MIN_HSPEED) ? S_FMA : S_AD;
                    end
                end
                S_FMA: r_st <= S_FMB;
                S_FMB: begin r_fm <= satu31($unsigned(r_p) >> 16); r_st <= S_FMC; end
                S_FMC: r_st <= S_FMD;
                S_FMD: begin
                    r_fm <= satu31($unsigned(r_p) >> 16);
                    r_ax <= 2'd0;
                    r_st <= S_FRM;
                end
                S_FRM: r_st <= S_FRD;
                S_FRD: r_st <= S_FRW;
                S_FRW: begin
                    if (ds_rsp.done) begin
                        r_f[r_ax] <= r_f[r_ax] - ds_rsp.res[33:0];
                        if (r_ax == 2'd0) begin
                            r_ax <= 2'd2;
                            r_st <= S_FRM;
                        end else begin
                            r_ax <= 2'd0;
                            r_st <= S_AD;
                        end
                    end
                end
                S_AD: r_st <= S_AW;
                S_AW: begin
                    if (ds_rsp.done) begin
                        r_acc <= sat32(ds_rsp.res);
                        r_st  <= S_AM;
                    end
                end
                S_AM: r_st <= S_AU;
                S_AU: begin
                    if (r_rot) begin
                        r_spin[r_ax] <= ax_new;
                    end else begin
                        r_vel[r_ax] <= ax_new;
                    end
                    if (r_ax == 2'd2) begin
                        r_ax  <= 2'd0;
                        r_rot <= 1'b1;
                        r_st  <= r_rot ? S_PM : S_AD;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                        r_st <= S_AD;
                    end
                end
                S_PM: r_st <= S_PU;
                S_PU: begin r_pos[r_ax] <= pos_fin; r_st <= S_PS; end
                S_PS: begin
                    r_sum <= ((r_ax == 2'd0) ? 64'd0 : r_sum) + $unsigned(r_p);
                    if (r_ax == 2'd2) begin
                        r_st <= S_SQ;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                        r_st <= S_PM;
                    end
                end
                S_SQ: r_st <= S_SW;
                S_SW: begin
                    if (ds_rsp.done) begin
                        r_speed <= satu31($unsigned(ds_rsp.res));
                        r_t     <= '0;
                        r_st    <= S_DM;
                    end
                end
                S_DM: r_st <= S_DA;
                S_DA: begin
                    r_dqacc <= dq_sum;
                    if (term.last) begin
                        r_dq[term.c] <= dq_cl;
                    end
                    if (r_t == 4'd11) begin
                        r_ax <= 2'd0;
                        r_st <= S_QH;
                    end else begin
                        r_t  <= r_t + 4'd1;
                        r_st <= S_DM;
                    end
                end
                S_QH: r_st <= S_QL;
                S_QL: begin r_hp <= r_p <<< 16; r_st <= S_QU; end
                S_QU: begin r_q[r_ax] <= q_cl; r_st <= S_QS; end
                S_QS: r_st <= S_QA;
                S_QA: begin
                    r_sum <= ((r_ax == 2'd0) ? 64'd0 : r_sum) + $unsigned(r_p);
                    if (r_ax == 2'd3) begin
                        r_st <= S_NQ;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                        r_st <= S_QH;
                    end
                end
                S_NQ: r_st <= S_NW;
                S_NW: begin
                    if (ds_rsp.done) begin
                        r_n  <= ds_rsp.res[31:0];
                        r_ax <= 2'd0;
                        if (ds_rsp.res == 64'sd0) begin
                            r_q[0] <= QUAT_ONE;
                            r_q[1] <= '0;
                            r_q[2] <= '0;
                            r_q[3] <= '0;
                            r_st   <= S_DONE;
                        end else begin
                            r_st <= S_ND;
                        end
                    end
                end
                S_ND: r_st <= S_NDW;
                S_NDW: begin
                    if (ds_rsp.done) begin
                        r_q[r_ax] <= ds_rsp.res[31:0];
                        if (r_ax == 2'd3) begin
                            r_st <= S_DONE;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                            r_st <= S_ND;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.pos_x  <= r_pos[0];
                        r_out.pos_y  <= r_pos[1];
                        r_out.pos_z  <= r_pos[2];
                        r_out.vel_x  <= r_vel[0];
                        r_out.vel_y  <= r_vel[1];
                        r_out.vel_z  <= r_vel[2];
                        r_out.speed  <= r_speed;
                        r_out.quat_w <= r_q[0];
                        r_out.quat_x <= r_q[1];
                        r_out.quat_y <= r_q[2];
                        r_out.quat_z <= r_q[3];
                        r_ovalid     <= 1'b1;
                        r_st         <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

### hw/rtl/rbes_checker.sv
// Port-level checks for the rigid body integrator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rbes_checker import rbes_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input t_in_item          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_item         o_out_data,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transfer dropped before acceptance");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result issued while sequencer still busy");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear the sequencer");

endmodule

bind rigid_body_euler_step rbes_checker u_rbes_checker (.*);
`default_nettype wire
